// ----- src/assert_macros.svh -----
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

// ----- src/bpv_pkg.sv -----
package bpv_pkg;

  // Request opcodes carried on in_tuser
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_VOTE    = 2'd1,
    OP_ABSTAIN = 2'd2,
    OP_DECIDE  = 2'd3
  } op_t;

  // Tally counts saturate
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_IDX_BIT = 3;  // registers sit on 8-byte strides
  localparam logic REG_CURRENT = 1'b0;
  localparam logic REG_TARGET  = 1'b1;

  // Control part of the token that walks the cell chain
  typedef struct packed {
    logic vld;    // token present at this stage
    logic dec;    // decide scan (else tally)
    logic found;  // tally already placed
  } tok_ctl_t;

endpackage

// ----- src/bpv_cell.sv -----
module bpv_cell #(
  parameter int VALUE_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  bpv_pkg::tok_ctl_t          ctl_i,
  input  logic [VALUE_BITS-1:0]      key_i,
  input  logic [VALUE_BITS-1:0]      lo_i,
  input  logic [VALUE_BITS-1:0]      hi_i,
  input  logic [bpv_pkg::CNT_W-1:0]  wgt_i,
  output bpv_pkg::tok_ctl_t          ctl_o,
  output logic [VALUE_BITS-1:0]      key_o,
  output logic [VALUE_BITS-1:0]      lo_o,
  output logic [VALUE_BITS-1:0]      hi_o,
  output logic [bpv_pkg::CNT_W-1:0]  wgt_o
);
  import bpv_pkg::*;

  // Slot held by this cell
  logic                  used_r, used_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // Token stage register toward the next cell
  tok_ctl_t              ctl_r, ctl_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] lo_r, hi_r;
  logic [CNT_W-1:0]      wgt_r, wgt_nxt;

  logic hit, in_range, better;

  assign hit      = used_r && (val_r == key_i);
  assign in_range = used_r && (val_r >= lo_i) && (val_r <= hi_i);
  assign better   = (cnt_r > wgt_i) || ((cnt_r == wgt_i) && (val_r < key_i));

  always_comb begin
    used_nxt = used_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    ctl_nxt  = ctl_i;
    key_nxt  = key_i;
    wgt_nxt  = wgt_i;
    if (clear) begin
      used_nxt = 1'b0;
    end else if (ctl_i.vld && ctl_i.dec) begin
      // decide: keep the best in-range slot seen so far, low value wins ties
      if (in_range && better) begin
        key_nxt = val_r;
        wgt_nxt = cnt_r;
      end
    end else if (ctl_i.vld && !ctl_i.found) begin
      // tally: bump a match, or claim this slot if it is the first free one
      if (hit) begin
        if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + CNT_ONE;
        ctl_nxt.found = 1'b1;
      end else if (!used_r) begin
        used_nxt      = 1'b1;
        val_nxt       = key_i;
        cnt_nxt       = CNT_ONE;
        ctl_nxt.found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      used_r <= used_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    key_r <= key_nxt;
    lo_r  <= lo_i;
    hi_r  <= hi_i;
    wgt_r <= wgt_nxt;
  end

  assign ctl_o = ctl_r;
  assign key_o = key_r;
  assign lo_o  = lo_r;
  assign hi_o  = hi_r;
  assign wgt_o = wgt_r;

endmodule

// ----- src/bounded_plurality_vote_core.sv -----
// Plurality vote over a bounded range. Each cell of a row of TABLE_ENTRIES
// cells holds one distinct voted value and its saturating 8-bit count. Every
// request becomes a token that walks the row one cell per clock: a tally
// token bumps the matching cell or claims the first free one (a full row
// drops the value and sets the sticky overflow flag), a decide token picks
// the highest-count value between current_value and target_value, lowest
// value on ties, falling back to current_value. One request is in the row at
// a time, so in_tready stays low until the token leaves the last cell, and
// while the second result slot is full; a decide result is registered into
// the two-deep output buffer as the token retires. A start request empties
// the row in its accept cycle. No clearing pass is needed after reset.
module bounded_plurality_vote_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int VALUE_BITS    = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]  in_tdata,   // [VALUE_BITS-1:0] vote_value
  input  logic [1:0]                       in_tuser,   // [1:0] opcode
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]  out_tdata,  // [VALUE_BITS-1:0] chosen_value
  output logic                             out_tuser,  // [0] table_overflow
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bpv_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bpv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bpv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import bpv_pkg::*;

  localparam int TD_W = ((VALUE_BITS + 7) / 8) * 8;

  // Registers
  logic [VALUE_BITS-1:0] cur_r, tgt_r;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      tgt_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[CFG_IDX_BIT] == REG_CURRENT) cur_r <= cfg_pwdata[VALUE_BITS-1:0];
      if (cfg_paddr[CFG_IDX_BIT] == REG_TARGET)  tgt_r <= cfg_pwdata[VALUE_BITS-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_IDX_BIT] == REG_TARGET) ? CFG_DATA_W'(tgt_r)
                                                              : CFG_DATA_W'(cur_r);

  // Request intake and token launch
  op_t                   op;
  logic                  in_acc;
  logic                  busy_r;
  logic                  start_clr;
  tok_ctl_t              l_ctl_r;
  logic [VALUE_BITS-1:0] l_key_r, l_lo_r, l_hi_r;
  logic [VALUE_BITS-1:0] key_sel;

  // Token wires between cells, index 0 is the launch register
  tok_ctl_t              ctl_w [TABLE_ENTRIES+1];
  logic [VALUE_BITS-1:0] key_w [TABLE_ENTRIES+1];
  logic [VALUE_BITS-1:0] lo_w  [TABLE_ENTRIES+1];
  logic [VALUE_BITS-1:0] hi_w  [TABLE_ENTRIES+1];
  logic [CNT_W-1:0]      wgt_w [TABLE_ENTRIES+1];

  // Output buffer, two deep
  logic                  out_vld_r, out_vld_nxt;
  logic [VALUE_BITS-1:0] out_val_r, out_val_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  skid_vld_r, skid_vld_nxt;
  logic [VALUE_BITS-1:0] skid_val_r, skid_val_nxt;
  logic                  skid_ovf_r, skid_ovf_nxt;
  logic                  ovf_r;
  logic                  done, push, pop;

  assign op        = op_t'(in_tuser);
  assign in_tready = !busy_r && !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign start_clr = in_acc && (op == OP_START);

  always_comb begin
    unique case (op)
      OP_START:   key_sel = tgt_r;
      OP_VOTE:    key_sel = in_tdata[VALUE_BITS-1:0];
      OP_ABSTAIN: key_sel = cur_r;
      OP_DECIDE:  key_sel = cur_r;  // initial best
      default:    key_sel = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_ctl_r <= '0;
    end else begin
      l_ctl_r.vld   <= in_acc;
      l_ctl_r.dec   <= (op == OP_DECIDE);
      l_ctl_r.found <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    l_key_r <= key_sel;
    l_lo_r  <= (cur_r < tgt_r) ? cur_r : tgt_r;
    l_hi_r  <= (cur_r < tgt_r) ? tgt_r : cur_r;
  end

  assign ctl_w[0] = l_ctl_r;
  assign key_w[0] = l_key_r;
  assign lo_w[0]  = l_lo_r;
  assign hi_w[0]  = l_hi_r;
  assign wgt_w[0] = '0;

  // Row of tally cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    bpv_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clear (start_clr),
      .ctl_i (ctl_w[i]),
      .key_i (key_w[i]),
      .lo_i  (lo_w[i]),
      .hi_i  (hi_w[i]),
      .wgt_i (wgt_w[i]),
      .ctl_o (ctl_w[i+1]),
      .key_o (key_w[i+1]),
      .lo_o  (lo_w[i+1]),
      .hi_o  (hi_w[i+1]),
      .wgt_o (wgt_w[i+1])
    );
  end

  // End of row: retire the token
  assign done = ctl_w[TABLE_ENTRIES].vld;
  assign push = done && ctl_w[TABLE_ENTRIES].dec;
  assign pop  = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      if (in_acc) busy_r <= 1'b1;
      else if (done) busy_r <= 1'b0;
      if (start_clr) ovf_r <= 1'b0;
      else if (done && !ctl_w[TABLE_ENTRIES].dec && !ctl_w[TABLE_ENTRIES].found) ovf_r <= 1'b1;
    end
  end

  // Result buffer update
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_val_nxt  = out_val_r;
    out_ovf_nxt  = out_ovf_r;
    skid_vld_nxt = skid_vld_r;
    skid_val_nxt = skid_val_r;
    skid_ovf_nxt = skid_ovf_r;
    if (pop) begin
      out_vld_nxt  = skid_vld_r;
      out_val_nxt  = skid_val_r;
      out_ovf_nxt  = skid_ovf_r;
      skid_vld_nxt = 1'b0;
    end
    if (push) begin
      if (!out_vld_nxt) begin
        out_vld_nxt = 1'b1;
        out_val_nxt = key_w[TABLE_ENTRIES];
        out_ovf_nxt = ovf_r;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_val_nxt = key_w[TABLE_ENTRIES];
        skid_ovf_nxt = ovf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r  <= out_val_nxt;
    out_ovf_r  <= out_ovf_nxt;
    skid_val_r <= skid_val_nxt;
    skid_ovf_r <= skid_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = TD_W'(out_val_r);
  assign out_tuser  = out_ovf_r;

endmodule

// ----- src/bpv_checker.sv -----
`include "assert_macros.svh"

module bpv_checker #(
  parameter int VALUE_BITS = 64
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [((VALUE_BITS+7)/8)*8-1:0]  out_tdata,
  input logic                             out_tuser,
  input logic                             cfg_pready
);

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // A stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))

  // Only one request walks the row at a time
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // No result can finish right after a request is taken
  `ASSERT_NEXT(a_no_early_result, clk, rst_n, in_tvalid && in_tready, !$rose(out_tvalid))

  // Register port never waits
  `ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind bounded_plurality_vote_core bpv_checker #(.VALUE_BITS(VALUE_BITS)) u_bpv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpv_pkg::*;

  localparam int TALLY_SLOTS = 64;
  localparam int VALUE_W     = 64;
  localparam int DATA_W      = ((VALUE_W + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int SEG_ITEMS   = 100;
  localparam logic [VALUE_W-1:0] ONES = '1;

  // one expected decide result
  typedef struct {
    logic [VALUE_W-1:0] chosen;
    logic               overflow;
  } choice_t;

  // tally table mirror and queue of pending decide results
  class plurality_board;
    logic [VALUE_W-1:0] cur_val;
    logic [VALUE_W-1:0] tgt_val;
    logic [VALUE_W-1:0] slot_val[TALLY_SLOTS];
    logic [CNT_W-1:0]   slot_cnt[TALLY_SLOTS];
    int                 used;
    logic               ovf;
    choice_t            pending_choices[$];
    int                 errors;

    function new();
      cur_val = '0;
      tgt_val = '0;
      foreach (slot_val[i]) begin
        slot_val[i] = '0;
        slot_cnt[i] = '0;
      end
      used   = 0;
      ovf    = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [VALUE_W-1:0] v);
      if (idx == REG_CURRENT) begin
        cur_val = v;
      end else begin
        tgt_val = v;
      end
    endfunction

    // bump the matching slot or claim a free one; a full table drops the value
    function void tally_value(logic [VALUE_W-1:0] v);
      for (int i = 0; i < used; i++) begin
        if (slot_val[i] == v) begin
          if (slot_cnt[i] != CNT_MAX) slot_cnt[i] = slot_cnt[i] + CNT_ONE;
          return;
        end
      end
      if (used < TALLY_SLOTS) begin
        slot_val[used] = v;
        slot_cnt[used] = CNT_ONE;
        used++;
      end else begin
        ovf = 1'b1;
      end
    endfunction

    // highest count in [lo, hi], smallest value on ties, else current
    function logic [VALUE_W-1:0] pick_winner();
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      logic [VALUE_W-1:0] best;
      int                 weight;
      lo     = (cur_val < tgt_val) ? cur_val : tgt_val;
      hi     = (cur_val < tgt_val) ? tgt_val : cur_val;
      best   = cur_val;
      weight = 0;
      for (int i = 0; i < used; i++) begin
        if (slot_val[i] >= lo && slot_val[i] <= hi && slot_cnt[i] != '0) begin
          if (int'(slot_cnt[i]) > weight ||
              (int'(slot_cnt[i]) == weight && slot_val[i] < best)) begin
            best   = slot_val[i];
            weight = int'(slot_cnt[i]);
          end
        end
      end
      return best;
    endfunction

    function void note_request(op_t op, logic [VALUE_W-1:0] v);
      choice_t c;
      case (op)
        OP_START: begin
          foreach (slot_cnt[i]) slot_cnt[i] = '0;
          used = 0;
          ovf  = 1'b0;
          tally_value(tgt_val);
        end
        OP_VOTE:    tally_value(v);
        OP_ABSTAIN: tally_value(cur_val);
        default: begin
          c.chosen   = pick_winner();
          c.overflow = ovf;
          pending_choices.push_back(c);
        end
      endcase
    endfunction

    function void check_choice(logic [VALUE_W-1:0] got_val, logic got_ovf);
      choice_t want;
      if (pending_choices.size() == 0) begin
        $display("%0t: unexpected result chosen_value %h table_overflow %b",
                 $time, got_val, got_ovf);
        errors++;
        return;
      end
      want = pending_choices.pop_front();
      if (got_val !== want.chosen) begin
        $display("%0t: chosen_value expected %h actual %h", $time, want.chosen, got_val);
        errors++;
      end
      if (got_ovf !== want.overflow) begin
        $display("%0t: table_overflow expected %b actual %b",
                 $time, want.overflow, got_ovf);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  plurality_board board;
  int send_idle_pct = 10;
  int recv_idle_pct = 71;
  int sent_count = 0;

  bounded_plurality_vote_core #(
    .TABLE_ENTRIES(TALLY_SLOTS),
    .VALUE_BITS   (VALUE_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // handshake monitor: results are checked before new requests are noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_choice(out_tdata[VALUE_W-1:0], out_tuser);
      if (in_tvalid && in_tready) board.note_request(op_t'(in_tuser), in_tdata[VALUE_W-1:0]);
    end
  end

  // watchdog on cycles without any accepted transfer or register access
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [VALUE_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [VALUE_W-1:0] in_range_value();
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] span;
    lo   = (board.cur_val < board.tgt_val) ? board.cur_val : board.tgt_val;
    span = ((board.cur_val < board.tgt_val) ? board.tgt_val : board.cur_val) - lo;
    if (span == ONES) return rand64();
    return lo + rand64() % (span + 1);
  endfunction

  // vote values clustered around the range bounds
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    lo = (board.cur_val < board.tgt_val) ? board.cur_val : board.tgt_val;
    hi = (board.cur_val < board.tgt_val) ? board.tgt_val : board.cur_val;
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      2, 3:    return in_range_value();
      4:       return lo - 1;
      5:       return hi + 1;
      6:       return rand64();
      default: return VALUE_W'($urandom_range(3));
    endcase
  endfunction

  // one request; called at a clock edge, returns at its accept edge
  task automatic send(op_t op, logic [VALUE_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= DATA_W'(v);
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sent_count++;
  endtask

  // drain all results and let the last tally finish its walk
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending_choices.size() != 0) @(posedge clk);
    repeat (TALLY_SLOTS + 8) @(posedge clk);
  endtask

  // setup phase, access phase, then an idle gap before returning
  task automatic write_reg(logic idx, logic [VALUE_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_BIT;
    cfg_pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(idx, v);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_setting();
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    a = rand64();
    b = rand64();
    case ($urandom_range(7))
      0: begin
        write_reg(REG_CURRENT, '0);
        write_reg(REG_TARGET, ONES);
      end
      1: begin
        write_reg(REG_CURRENT, ONES);
        write_reg(REG_TARGET, '0);
      end
      2: begin
        write_reg(REG_CURRENT, a);
        write_reg(REG_TARGET, a);
      end
      3: begin
        write_reg(REG_CURRENT, a);
        write_reg(REG_TARGET, a + VALUE_W'($urandom_range(40)));
      end
      4: begin
        write_reg(REG_CURRENT, '0);
        write_reg(REG_TARGET, '0);
      end
      5: begin
        write_reg(REG_CURRENT, ONES);
        write_reg(REG_TARGET, ONES);
      end
      6: write_reg(REG_CURRENT, a);
      default: write_reg(REG_TARGET, b);
    endcase
  endtask

  // start, up to 14 votes, abstains and decides, then a decide
  task automatic tally_round();
    send(OP_START, rand64());
    repeat ($urandom_range(1, 14)) begin
      case ($urandom_range(9))
        0:       send(OP_ABSTAIN, rand64());
        1:       send(OP_DECIDE, rand64());
        default: send(OP_VOTE, pick_value());
      endcase
      // current setting moves in the middle of a tally
      if ($urandom_range(30) == 0) begin
        settle();
        write_reg(REG_CURRENT, pick_value());
      end
    end
    send(OP_DECIDE, rand64());
  endtask

  // requests in any order, no start first
  task automatic noise_round();
    repeat ($urandom_range(1, 8)) send(op_t'($urandom_range(3)), pick_value());
  endtask

  // fill the table past its size, overflow stays set until the next start
  task automatic overflow_round();
    send(OP_START, rand64());
    repeat (TALLY_SLOTS + $urandom_range(10, 20)) begin
      send(OP_VOTE, ($urandom_range(15) == 0) ? pick_value() : rand64());
    end
    send(OP_DECIDE, rand64());
    send(OP_VOTE, rand64());
    send(OP_ABSTAIN, rand64());
    send(OP_DECIDE, rand64());
    send(OP_START, rand64());
    send(OP_DECIDE, rand64());
  endtask

  // drive two in-range values to the count ceiling so they tie
  task automatic saturation_round();
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    a = in_range_value();
    b = in_range_value();
    send(OP_START, rand64());
    for (int i = 0; i < 2 * int'(CNT_MAX) + 8; i++) begin
      if ($urandom_range(40) == 0) begin
        send(OP_ABSTAIN, rand64());
      end else begin
        send(OP_VOTE, i[0] ? b : a);
      end
    end
    send(OP_DECIDE, rand64());
    send(OP_VOTE, a);
    send(OP_DECIDE, rand64());
  endtask

  initial begin : main
    int send_pct[3];
    int recv_pct[3];
    int seg_start;
    send_pct = '{10, 71, 0};
    recv_pct = '{71, 10, 0};
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // before any start: empty table, then votes into the reset table
    send(OP_DECIDE, '0);
    send(OP_ABSTAIN, ONES);
    send(OP_VOTE, 64'd5);
    send(OP_DECIDE, ONES);
    settle();
    write_reg(REG_CURRENT, '0);
    write_reg(REG_TARGET, ONES);
    send(OP_VOTE, ONES);
    // start, then a tie between both extremes goes to the smaller
    send(OP_START, 64'h0123_4567_89ab_cdef);
    send(OP_VOTE, '0);
    send(OP_VOTE, '0);
    send(OP_VOTE, ONES);
    send(OP_DECIDE, '0);
    // bounds swapped, abstain votes for current
    settle();
    write_reg(REG_CURRENT, ONES);
    write_reg(REG_TARGET, '0);
    send(OP_ABSTAIN, '0);
    send(OP_DECIDE, '0);
    // one-point range, neighbors and bit patterns fall outside
    settle();
    write_reg(REG_CURRENT, 64'h8000_0000_0000_0000);
    write_reg(REG_TARGET, 64'h8000_0000_0000_0000);
    send(OP_START, ONES);
    send(OP_VOTE, 64'h7fff_ffff_ffff_ffff);
    send(OP_VOTE, 64'h8000_0000_0000_0001);
    send(OP_VOTE, 64'h5555_5555_5555_5555);
    send(OP_VOTE, 64'haaaa_aaaa_aaaa_aaaa);
    send(OP_DECIDE, ONES);
    // range widens before decide
    settle();
    write_reg(REG_CURRENT, '0);
    send(OP_DECIDE, '0);

    // random part, three backpressure mixes
    for (int seg = 0; seg < 3; seg++) begin
      settle();
      send_idle_pct = send_pct[seg];
      recv_idle_pct = recv_pct[seg];
      seg_start = sent_count;
      pick_setting();
      overflow_round();
      if (seg == 2) begin
        settle();
        pick_setting();
        saturation_round();
      end
      while (sent_count - seg_start < SEG_ITEMS) begin
        settle();
        pick_setting();
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(9) == 0) begin
            noise_round();
          end else begin
            tally_round();
          end
        end
      end
    end

    settle();
    if (board.errors == 0 && board.pending_choices.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/bpv_pkg.sv
src/bpv_cell.sv
src/bounded_plurality_vote_core.sv
src/bpv_checker.sv
bench/tb_top.sv
